@@ rtl/core/pts_pkg.sv @@
`timescale 1ns / 1ps

package pts_pkg;

  // Fixed field widths of the beats
  localparam int W_TAG   = 8;
  localparam int W_PRIO  = 8;
  localparam int W_BURST = 16;
  localparam int W_TIME  = 21;
  localparam int W_AVG   = 29;
  localparam int W_COUNT = 6;
  localparam int W_FRAC  = 8;

  // Request action codes
  localparam logic ACT_ADD      = 1'b0;
  localparam logic ACT_SCHEDULE = 1'b1;

  // Response kinds
  localparam logic [1:0] KIND_ACK      = 2'd0;
  localparam logic [1:0] KIND_DISPATCH = 2'd1;
  localparam logic [1:0] KIND_METRICS  = 2'd2;

  // Add acknowledge status
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FULL = 1'b1;

  typedef struct packed {
    logic               action;
    logic [W_TAG-1:0]   task_tag;
    logic [W_PRIO-1:0]  priority_req;
    logic [W_BURST-1:0] burst;
  } req_beat_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               status;
    logic [W_TAG-1:0]   run_tag;
    logic [W_BURST-1:0] run_burst;
    logic [W_TIME-1:0]  start_time;
    logic [W_TIME-1:0]  finish_time;
    logic [W_AVG-1:0]   avg_turnaround;
    logic [W_AVG-1:0]   avg_response;
    logic [W_AVG-1:0]   avg_wait;
    logic [W_COUNT-1:0] tasks_run;
    logic               last;
  } rsp_beat_t;

  // Table entry as stored in the task memory
  typedef struct packed {
    logic [W_TAG-1:0]   tag;
    logic [W_PRIO-1:0]  prio;
    logic [W_BURST-1:0] burst;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_DISPATCH,
    S_DIV_TA,
    S_DIV_RESP,
    S_METRICS
  } state_t;

endpackage

@@ rtl/core/pts_divider.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module pts_divider #(
  parameter int DW = 36,
  parameter int CW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [CW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int NW = $clog2(DW + 1);

  logic [NW-1:0] steps;
  logic [CW-1:0] rem;
  logic [DW-1:0] quo;
  logic [CW:0]   shifted;
  logic [CW:0]   diff;
  logic          fits;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    shifted = {rem, quo[DW-1]};
    diff    = shifted - {1'b0, divisor};
    fits    = (shifted >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= NW'(DW);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == NW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[CW-1:0] : shifted[CW-1:0];
      quo <= {quo[DW-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

@@ rtl/core/priority_task_scheduler.sv @@
`timescale 1ns / 1ps

// Non-preemptive priority scheduler over a table of up to TASKS tasks. An add
// beat stores one task (tag, priority, burst) and answers with one acknowledge
// beat, status full when the table already holds TASKS tasks. A schedule beat
// drains the table: for each task, the highest priority first and the most
// recently added first among equals, it gives one dispatch beat with start and
// finish times counted from 0, then one metrics beat with the task count and
// the floored averages of finish and start times in 8-bit fixed point (0 when
// the table was empty). Each dispatch is one full pass over the single-port
// task memory, and the two averages come one after the other from a bit-serial
// divider of width DW = 24 + 2 * clog2(TASKS + 1) (36 for TASKS = 32). No new
// request is taken while a beat is in progress; the last response can wait in
// its output register meanwhile.
module priority_task_scheduler #(
  parameter int TASKS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  pts_pkg::req_beat_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output pts_pkg::rsp_beat_t rsp
);

  import pts_pkg::*;

  localparam int IW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int CW = $clog2(TASKS + 1);
  localparam int TW = W_BURST + CW;
  localparam int SW = TW + CW;
  localparam int DW = SW + W_FRAC;
  localparam logic [IW-1:0] LAST_IDX = IW'(TASKS - 1);

  state_t state, state_next;

  // Task memory; slot order equals slot index since adds fill slots in turn
  entry_t           mem [TASKS];
  logic [TASKS-1:0] slot_valid;
  logic [CW-1:0]    pending;

  // Scan pipeline
  logic [IW-1:0] scan_addr;
  logic          issuing;
  logic          rd_valid;
  logic [IW-1:0] rd_idx;
  entry_t        rd_ent;
  logic          ent_valid;

  // Best candidate of the current pass
  logic          found;
  logic [IW-1:0] best_idx;
  entry_t        best;

  // Schedule accumulators
  logic [TW-1:0] now;
  logic [SW-1:0] sum_start;
  logic [SW-1:0] sum_finish;
  logic [CW-1:0] run_count;
  logic          add_full;
  logic [DW-1:0] avg_ta;
  logic [DW-1:0] avg_resp;

  // Divider hookup
  logic          div_start;
  logic [DW-1:0] div_dividend;
  logic          div_busy;
  logic          div_done;
  logic [DW-1:0] div_quo;

  // Control decode
  logic      req_take;
  logic      rsp_free;
  logic      rsp_load;
  rsp_beat_t rsp_next;
  logic      scan_init;
  logic      take;
  logic      found_now;
  logic      scan_end;
  logic [TW-1:0] finish;

  logic [DW+W_AVG-1:0]    ta_ext;
  logic [DW+W_AVG-1:0]    resp_ext;
  logic [TW+W_TIME-1:0]   start_ext;
  logic [TW+W_TIME-1:0]   finish_ext;
  logic [CW+W_COUNT-1:0]  count_ext;

  assign req_take = req_valid && !req_stall;
  assign rsp_free = !rsp_valid || !rsp_stall;

  // Candidate compare: later slot wins a priority tie
  always_comb begin
    take      = rd_valid && ent_valid && (!found || (rd_ent.prio >= best.prio));
    found_now = found || take;
    scan_end  = rd_valid && (rd_idx == LAST_IDX);
    finish    = now + TW'(best.burst);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = (req.action == ACT_ADD) ? S_ADD : S_SCAN;
        end
      end
      S_ADD: begin
        if (rsp_free) state_next = S_IDLE;
      end
      S_SCAN: begin
        if (scan_end) state_next = found_now ? S_DISPATCH : S_DIV_TA;
      end
      S_DISPATCH: begin
        if (rsp_free) state_next = S_SCAN;
      end
      S_DIV_TA: begin
        if (div_done) state_next = S_DIV_RESP;
      end
      S_DIV_RESP: begin
        if (div_done) state_next = S_METRICS;
      end
      S_METRICS: begin
        if (rsp_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Field widening for the response
  always_comb begin
    ta_ext     = {{W_AVG{1'b0}}, avg_ta};
    resp_ext   = {{W_AVG{1'b0}}, avg_resp};
    start_ext  = {{W_TIME{1'b0}}, now};
    finish_ext = {{W_TIME{1'b0}}, finish};
    count_ext  = {{W_COUNT{1'b0}}, run_count};
  end

  // Outputs of the sequencer
  always_comb begin
    req_stall    = (state != S_IDLE);
    rsp_load     = 1'b0;
    rsp_next     = '0;
    scan_init    = 1'b0;
    div_start    = 1'b0;
    div_dividend = {sum_start, {W_FRAC{1'b0}}};
    unique case (state)
      S_IDLE: begin
        scan_init = req_valid && (req.action == ACT_SCHEDULE);
      end
      S_ADD: begin
        rsp_load      = rsp_free;
        rsp_next.kind = KIND_ACK;
        rsp_next.status = add_full ? STAT_FULL : STAT_OK;
        rsp_next.last = 1'b1;
      end
      S_SCAN: begin
        div_start    = scan_end && !found_now;
        div_dividend = {sum_finish, {W_FRAC{1'b0}}};
      end
      S_DISPATCH: begin
        rsp_load             = rsp_free;
        scan_init            = rsp_free;
        rsp_next.kind        = KIND_DISPATCH;
        rsp_next.run_tag     = best.tag;
        rsp_next.run_burst   = best.burst;
        rsp_next.start_time  = start_ext[W_TIME-1:0];
        rsp_next.finish_time = finish_ext[W_TIME-1:0];
      end
      S_DIV_TA: begin
        div_start = div_done;
      end
      S_DIV_RESP: begin
      end
      S_METRICS: begin
        rsp_load      = rsp_free;
        rsp_next.kind = KIND_METRICS;
        if (run_count != '0) begin
          rsp_next.avg_turnaround = ta_ext[W_AVG-1:0];
          rsp_next.avg_response   = resp_ext[W_AVG-1:0];
          rsp_next.avg_wait       = resp_ext[W_AVG-1:0];
        end
        rsp_next.tasks_run = count_ext[W_COUNT-1:0];
        rsp_next.last      = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) rsp <= rsp_next;
  end

  // Task memory write and registered read
  always_ff @(posedge clk) begin
    if (req_take && (req.action == ACT_ADD) && (pending != CW'(TASKS))) begin
      mem[pending[IW-1:0]] <= '{tag: req.task_tag, prio: req.priority_req,
                                burst: req.burst};
    end
    if (issuing) rd_ent <= mem[scan_addr];
  end

  // Valid bits and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      pending    <= '0;
    end else begin
      if (req_take && (req.action == ACT_ADD) && (pending != CW'(TASKS))) begin
        slot_valid[pending[IW-1:0]] <= 1'b1;
        pending <= pending + 1'b1;
      end
      if ((state == S_DISPATCH) && rsp_free) slot_valid[best_idx] <= 1'b0;
      if ((state == S_SCAN) && scan_end && !found_now) pending <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) add_full <= (pending == CW'(TASKS));
  end

  // Scan address sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing  <= 1'b0;
      rd_valid <= 1'b0;
      found    <= 1'b0;
    end else if (scan_init) begin
      issuing  <= 1'b1;
      rd_valid <= 1'b0;
      found    <= 1'b0;
    end else begin
      rd_valid <= issuing;
      if (issuing && (scan_addr == LAST_IDX)) issuing <= 1'b0;
      if (take) found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_init) begin
      scan_addr <= '0;
    end else if (issuing && (scan_addr != LAST_IDX)) begin
      scan_addr <= scan_addr + 1'b1;
    end
    rd_idx    <= scan_addr;
    ent_valid <= slot_valid[scan_addr];
    if (take) begin
      best_idx <= rd_idx;
      best     <= rd_ent;
    end
  end

  // Time and sum accumulators
  always_ff @(posedge clk) begin
    if (req_take && (req.action == ACT_SCHEDULE)) begin
      now        <= '0;
      sum_start  <= '0;
      sum_finish <= '0;
      run_count  <= '0;
    end else if ((state == S_DISPATCH) && rsp_free) begin
      now        <= finish;
      sum_start  <= sum_start + SW'(now);
      sum_finish <= sum_finish + SW'(finish);
      run_count  <= run_count + 1'b1;
    end
    if ((state == S_DIV_TA) && div_done)   avg_ta   <= div_quo;
    if ((state == S_DIV_RESP) && div_done) avg_resp <= div_quo;
  end

  pts_divider #(
    .DW (DW),
    .CW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (run_count),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

`ifndef SYNTH
  // Fill count never passes the table size
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= CW'(TASKS))
    else $error("pending count exceeds table size");

  // Between requests the fill count matches the set valid bits
  a_pending_match: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(slot_valid) == 32'(pending)))
    else $error("fill count and valid bits disagree");

  // A drained table is fully empty by the metrics beat
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_METRICS) |-> ((slot_valid == '0) && (pending == '0)))
    else $error("table not empty at metrics");

  // Divider is never restarted mid-division
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // Dispatch only follows a pass that found a task
  a_dispatch_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_DISPATCH) |-> found)
    else $error("dispatch without a candidate");
`endif

endmodule

@@ tb/sv/priority_task_scheduler_tb.sv @@
`timescale 1ns / 1ps

module priority_task_scheduler_tb;
  import pts_pkg::*;

  localparam int TASKS          = 32;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 200;
  localparam int RANDOM_ITEMS   = 400;
  localparam int PHASES         = 4;
  localparam int MAX_PRINTED    = 100;

  // Per phase: percent of idle request cycles, percent of stalled response cycles
  localparam int SEND_IDLE_PCT [PHASES] = '{0, 50, 0, 30};
  localparam int RSP_STALL_PCT [PHASES] = '{0, 0, 50, 30};

  // Responses that are obvious at a glance
  localparam rsp_beat_t ACK_OK   = '{kind: KIND_ACK, status: STAT_OK, last: 1'b1, default: '0};
  localparam rsp_beat_t ACK_FULL = '{kind: KIND_ACK, status: STAT_FULL, last: 1'b1, default: '0};
  localparam rsp_beat_t EMPTY_METRICS = '{kind: KIND_METRICS, last: 1'b1, default: '0};
  localparam rsp_beat_t NO_RSP   = '0;

  typedef struct packed {
    req_beat_t  beat;
    logic [5:0] reps;    // repeated beats bump the tag by one each time
    logic       typed;   // want holds the single response of this beat
    rsp_beat_t  want;
  } dir_row_t;

  localparam int DIR_LEN = 16;
  localparam dir_row_t DIR_ROWS [DIR_LEN] = '{
    // schedule with nothing stored
    '{'{ACT_SCHEDULE, 8'h00, 8'h00, 16'h0000}, 6'd1, 1'b1, EMPTY_METRICS},
    // field extremes, ties at the top and bottom priority
    '{'{ACT_ADD, 8'h00, 8'h00, 16'h0000}, 6'd1, 1'b1, ACK_OK},
    '{'{ACT_ADD, 8'hff, 8'hff, 16'hffff}, 6'd1, 1'b1, ACK_OK},
    '{'{ACT_ADD, 8'h5a, 8'hff, 16'h0001}, 6'd1, 1'b1, ACK_OK},
    '{'{ACT_ADD, 8'h33, 8'h80, 16'h1234}, 6'd1, 1'b1, ACK_OK},
    '{'{ACT_ADD, 8'ha5, 8'h00, 16'h0000}, 6'd1, 1'b1, ACK_OK},
    '{'{ACT_SCHEDULE, 8'hff, 8'hff, 16'hffff}, 6'd1, 1'b0, NO_RSP},
    // table was drained by the previous schedule
    '{'{ACT_SCHEDULE, 8'h00, 8'h00, 16'h0000}, 6'd1, 1'b1, EMPTY_METRICS},
    // single task
    '{'{ACT_ADD, 8'h11, 8'h07, 16'hffff}, 6'd1, 1'b1, ACK_OK},
    '{'{ACT_SCHEDULE, 8'h00, 8'h00, 16'h0000}, 6'd1, 1'b0, NO_RSP},
    // fill the table with longest bursts, all tied, then overflow
    '{'{ACT_ADD, 8'h80, 8'hff, 16'hffff}, 6'd32, 1'b0, NO_RSP},
    '{'{ACT_ADD, 8'hc3, 8'h01, 16'h0002}, 6'd1, 1'b1, ACK_FULL},
    '{'{ACT_ADD, 8'h3c, 8'hfe, 16'hfffe}, 6'd1, 1'b1, ACK_FULL},
    '{'{ACT_SCHEDULE, 8'h00, 8'h00, 16'h0000}, 6'd1, 1'b0, NO_RSP},
    // zero bursts: all times and averages stay at zero
    '{'{ACT_ADD, 8'h40, 8'h00, 16'h0000}, 6'd3, 1'b0, NO_RSP},
    '{'{ACT_SCHEDULE, 8'h00, 8'h00, 16'h0000}, 6'd1, 1'b0, NO_RSP}
  };

  logic      clk;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_beat_t req       = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_beat_t rsp;

  // Shadow of the task table; slots fill in arrival order, so a higher index
  // is a later add
  logic [W_TAG-1:0]   slot_tag_q   [TASKS];
  logic [W_PRIO-1:0]  slot_prio_q  [TASKS];
  logic [W_BURST-1:0] slot_burst_q [TASKS];
  bit                 slot_used_q  [TASKS];
  int unsigned        stored_tasks;

  rsp_beat_t   pending_rsp [$];
  rsp_beat_t   head_rsp;
  int unsigned err_count;
  int unsigned quiet_cycles;
  int unsigned beats_sent;
  int          send_idle_pct;
  int          stall_pct;

  priority_task_scheduler #(.TASKS(TASKS)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTED)
      $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // Scheduler prediction: acknowledge an add, or drain the table by priority
  task automatic predict_schedule(input req_beat_t b);
    rsp_beat_t        r;
    int               best;
    longint unsigned  now;
    longint unsigned  sum_start;
    longint unsigned  sum_finish;
    longint unsigned  n_run;
    logic [63:0]      avg;
    if (b.action == ACT_ADD) begin
      r = ACK_OK;
      if (stored_tasks >= TASKS) begin
        r.status = STAT_FULL;
      end else begin
        slot_tag_q[stored_tasks]   = b.task_tag;
        slot_prio_q[stored_tasks]  = b.priority_req;
        slot_burst_q[stored_tasks] = b.burst;
        slot_used_q[stored_tasks]  = 1'b1;
        stored_tasks++;
      end
      pending_rsp.push_back(r);
    end else begin
      now        = 0;
      sum_start  = 0;
      sum_finish = 0;
      n_run      = 0;
      do begin
        best = -1;
        for (int i = 0; i < TASKS; i++) begin
          if (slot_used_q[i] && (best < 0 || slot_prio_q[i] >= slot_prio_q[best]))
            best = i;
        end
        if (best >= 0) begin
          r             = '0;
          r.kind        = KIND_DISPATCH;
          r.run_tag     = slot_tag_q[best];
          r.run_burst   = slot_burst_q[best];
          r.start_time  = W_TIME'(now);
          sum_start    += now;
          now          += slot_burst_q[best];
          sum_finish   += now;
          r.finish_time = W_TIME'(now);
          slot_used_q[best] = 1'b0;
          n_run++;
          pending_rsp.push_back(r);
        end
      end while (best >= 0);
      stored_tasks = 0;
      r = EMPTY_METRICS;
      r.tasks_run = W_COUNT'(n_run);
      if (n_run != 0) begin
        avg = (sum_finish << W_FRAC) / n_run;
        r.avg_turnaround = avg[W_AVG-1:0];
        avg = (sum_start << W_FRAC) / n_run;
        r.avg_response = avg[W_AVG-1:0];
        r.avg_wait     = avg[W_AVG-1:0];
      end
      pending_rsp.push_back(r);
    end
  endtask

  function automatic req_beat_t random_request(input logic act);
    req_beat_t   b;
    int unsigned pick;
    pick = $urandom_range(7);
    b.action   = act;
    b.task_tag = W_TAG'($urandom_range(255));
    // half the priorities from a narrow range so ties are common
    b.priority_req = ($urandom_range(1) == 0) ? W_PRIO'($urandom_range(3))
                                              : W_PRIO'($urandom_range(255));
    case (pick)
      0:       b.burst = '1;
      1:       b.burst = '0;
      2, 3:    b.burst = W_BURST'($urandom_range(15, 1));
      default: b.burst = W_BURST'($urandom_range(65535));
    endcase
    return b;
  endfunction

  // One request beat: optional idle gap, then hold until accepted
  task automatic drive_request(input req_beat_t b, input bit typed, input rsp_beat_t want);
    int gap;
    @(negedge clk);
    gap = 0;
    while ($urandom_range(99) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= b;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    predict_schedule(b);
    if (typed)
      pending_rsp[pending_rsp.size() - 1] = want;
    beats_sent++;
  endtask

  // Hold off the sender until every predicted response has been seen
  task automatic wait_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0)
      @(posedge clk);
  endtask

  // Response stall pattern
  always @(negedge clk)
    rsp_stall <= ($urandom_range(99) < stall_pct);

  // Response checker and activity tracking
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch("response beat with nothing pending");
        end else begin
          head_rsp = pending_rsp.pop_front();
          check_field("kind", rsp.kind, head_rsp.kind);
          check_field("status", rsp.status, head_rsp.status);
          check_field("run_tag", rsp.run_tag, head_rsp.run_tag);
          check_field("run_burst", rsp.run_burst, head_rsp.run_burst);
          check_field("start_time", rsp.start_time, head_rsp.start_time);
          check_field("finish_time", rsp.finish_time, head_rsp.finish_time);
          check_field("avg_turnaround", rsp.avg_turnaround, head_rsp.avg_turnaround);
          check_field("avg_response", rsp.avg_response, head_rsp.avg_response);
          check_field("avg_wait", rsp.avg_wait, head_rsp.avg_wait);
          check_field("tasks_run", rsp.tasks_run, head_rsp.tasks_run);
          check_field("last", rsp.last, head_rsp.last);
        end
      end
    end
  end

  // Watchdog: too long without any beat on either channel
  initial begin
    @(negedge rst);
    while (quiet_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    $display("priority_task_scheduler test failed");
    $finish;
  end

  initial begin
    req_beat_t   beat;
    int unsigned phase_end;
    int unsigned n_adds;
    int unsigned roll;
    err_count     = 0;
    beats_sent    = 0;
    stored_tasks  = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    for (int i = 0; i < TASKS; i++)
      slot_used_q[i] = 1'b0;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed table
    for (int k = 0; k < DIR_LEN; k++) begin
      for (int j = 0; j < DIR_ROWS[k].reps; j++) begin
        beat = DIR_ROWS[k].beat;
        beat.task_tag = beat.task_tag + W_TAG'(j);
        drive_request(beat, DIR_ROWS[k].typed, DIR_ROWS[k].want);
      end
    end
    wait_drained();

    // Random part: mostly add runs closed by a schedule, some noise
    phase_end = beats_sent;
    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct = SEND_IDLE_PCT[ph];
      stall_pct     = RSP_STALL_PCT[ph];
      phase_end    += RANDOM_ITEMS / PHASES;
      while (beats_sent < phase_end) begin
        roll = $urandom_range(99);
        if (roll < 15) begin
          repeat ($urandom_range(6, 1))
            drive_request(random_request(1'($urandom_range(1))), 1'b0, NO_RSP);
        end else begin
          roll = $urandom_range(99);
          if (roll < 65)
            n_adds = $urandom_range(6);
          else if (roll < 90)
            n_adds = $urandom_range(20, 7);
          else
            n_adds = $urandom_range(TASKS + 4, TASKS - 2);
          repeat (n_adds)
            drive_request(random_request(ACT_ADD), 1'b0, NO_RSP);
          if ($urandom_range(9) == 0)
            wait_drained();
          drive_request(random_request(ACT_SCHEDULE), 1'b0, NO_RSP);
        end
      end
      wait_drained();
    end

    // Quiet tail: nothing more may come out
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_rsp.size() != 0)
      report_mismatch("responses still pending at end of run");
    if (err_count == 0)
      $display("priority_task_scheduler test passed");
    else
      $display("priority_task_scheduler test failed");
    $finish;
  end

endmodule
